// ===== rtl/scc_pkg.sv =====
package scc_pkg;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int FULL_W      = 10;

  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_RUN_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FULL_LEVEL       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MEASURE_INTERVAL = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TICKS       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CYCLE_TICKS      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_CYCLES       = 3'd5;

  localparam logic [1:0] STAT_DISCHARGED = 2'd0;
  localparam logic [1:0] STAT_CHARGING   = 2'd1;
  localparam logic [1:0] STAT_CHARGED    = 2'd2;
  localparam logic [1:0] STAT_CHARGED_ALT = 2'd3;

  localparam logic [1:0] IND_STANDBY  = 2'd0;
  localparam logic [1:0] IND_CHARGING = 2'd1;
  localparam logic [1:0] IND_CHARGED  = 2'd2;

  typedef struct packed {
    logic              first_run_mode;
    logic [FULL_W-1:0] full_level;
    logic [7:0]        measure_interval;
    logic [15:0]       hold_ticks;
    logic [15:0]       cycle_ticks;
    logic [7:0]        min_cycles;
  } cfg_t;

  typedef struct packed {
    logic [1:0] status_out;
    logic       charge_enable;
    logic [1:0] indicator;
    logic       blue_pulse;
  } result_t;

endpackage

// ===== rtl/scc_in_if.sv =====
interface scc_in_if #(
  parameter int ADC_BITS = 10
) ();
  logic                valid;
  logic                ready;
  logic                tick;
  logic [ADC_BITS-1:0] battery_sample;
  logic [ADC_BITS-1:0] solar_sample;
  logic [1:0]          status_in;

  modport source (
    output valid, tick, battery_sample, solar_sample, status_in,
    input  ready
  );

  modport sink (
    input  valid, tick, battery_sample, solar_sample, status_in,
    output ready
  );
endinterface

// ===== rtl/scc_out_if.sv =====
interface scc_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] status_out;
  logic       charge_enable;
  logic [1:0] indicator;
  logic       blue_pulse;

  modport source (
    output valid, status_out, charge_enable, indicator, blue_pulse,
    input  ready
  );

  modport sink (
    input  valid, status_out, charge_enable, indicator, blue_pulse,
    output ready
  );
endinterface

// ===== rtl/scc_cfg_regs.sv =====
module scc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [scc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [scc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output scc_pkg::cfg_t                      cfg
);
  import scc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_run_mode   <= 1'b0;
      cfg.full_level       <= 10'd900;
      cfg.measure_interval <= 8'd10;
      cfg.hold_ticks       <= 16'd600;
      cfg.cycle_ticks      <= 16'd600;
      cfg.min_cycles       <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_RUN_MODE:   cfg.first_run_mode   <= cfg_data[0];
        CFG_FULL_LEVEL:       cfg.full_level       <= cfg_data[FULL_W-1:0];
        CFG_MEASURE_INTERVAL: cfg.measure_interval <= cfg_data[7:0];
        CFG_HOLD_TICKS:       cfg.hold_ticks       <= cfg_data[15:0];
        CFG_CYCLE_TICKS:      cfg.cycle_ticks      <= cfg_data[15:0];
        CFG_MIN_CYCLES:       cfg.min_cycles       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/scc_core.sv =====
module scc_core #(
  parameter int ADC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  scc_pkg::cfg_t       cfg,
  input  logic                tick,
  input  logic [ADC_BITS-1:0] battery_sample,
  input  logic [ADC_BITS-1:0] solar_sample,
  input  logic [1:0]          status_in,
  output scc_pkg::result_t    result
);
  import scc_pkg::*;

  localparam int CMP_W = (ADC_BITS > FULL_W) ? ADC_BITS : FULL_W;

  logic [7:0]          measure_count, measure_count_next;
  logic [ADC_BITS-1:0] held_battery, held_battery_next;
  logic [ADC_BITS-1:0] held_solar, held_solar_next;
  logic                tick_pending, tick_pending_next;
  logic [15:0]         hold_timer, hold_timer_next;
  logic [ADC_BITS-1:0] peak_battery, peak_battery_next;
  logic [7:0]          cycle_count, cycle_count_next;

  logic [7:0] mc_inc;
  logic       pend;
  logic [1:0] st;

  always_comb begin
    measure_count_next = measure_count;
    held_battery_next  = held_battery;
    held_solar_next    = held_solar;
    tick_pending_next  = tick_pending;
    hold_timer_next    = hold_timer;
    peak_battery_next  = peak_battery;
    cycle_count_next   = cycle_count;
    mc_inc             = measure_count + 8'd1;
    pend               = tick_pending | tick;
    st                 = (status_in == STAT_CHARGED_ALT) ? STAT_CHARGED : status_in;
    result.charge_enable = 1'b0;
    result.indicator     = IND_STANDBY;
    result.blue_pulse    = 1'b0;

    if (tick) begin
      measure_count_next = mc_inc;
      if (mc_inc > cfg.measure_interval) begin
        held_battery_next  = battery_sample;
        held_solar_next    = solar_sample;
        measure_count_next = 8'd0;
      end
    end
    tick_pending_next = pend;

    if (held_solar_next > held_battery_next) begin
      if (st == STAT_CHARGED) begin
        result.indicator = IND_CHARGED;
        if (!cfg.first_run_mode) begin
          hold_timer_next = 16'd0;
        end
      end else begin
        result.charge_enable = 1'b1;
        result.indicator     = IND_CHARGING;
        st                   = STAT_CHARGING;
        if (cfg.first_run_mode) begin
          if (peak_battery < held_battery_next) begin
            peak_battery_next = held_battery_next;
            hold_timer_next   = 16'd0;
            cycle_count_next  = 8'd0;
          end
          if (pend) begin
            tick_pending_next = 1'b0;
            hold_timer_next   = hold_timer_next + 16'd1;
            if (hold_timer_next > cfg.cycle_ticks) begin
              cycle_count_next = cycle_count_next + 8'd1;
              hold_timer_next  = 16'd0;
            end
          end
          if (cycle_count_next > cfg.min_cycles) begin
            st = STAT_CHARGED;
          end
        end else if (CMP_W'(held_battery_next) >= CMP_W'(cfg.full_level) && pend) begin
          tick_pending_next = 1'b0;
          result.blue_pulse = 1'b1;
          hold_timer_next   = hold_timer + 16'd1;
          if (hold_timer_next > cfg.hold_ticks) begin
            st = STAT_CHARGED;
          end
        end
      end
    end else begin
      hold_timer_next = 16'd0;
      if (cfg.first_run_mode) begin
        peak_battery_next = '0;
      end else if (st == STAT_CHARGED) begin
        st = STAT_CHARGING;
      end
    end
    result.status_out = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      measure_count <= 8'd0;
      held_battery  <= '0;
      held_solar    <= '0;
      tick_pending  <= 1'b0;
      hold_timer    <= 16'd0;
      peak_battery  <= '0;
      cycle_count   <= 8'd0;
    end else if (step) begin
      measure_count <= measure_count_next;
      held_battery  <= held_battery_next;
      held_solar    <= held_solar_next;
      tick_pending  <= tick_pending_next;
      hold_timer    <= hold_timer_next;
      peak_battery  <= peak_battery_next;
      cycle_count   <= cycle_count_next;
    end
  end

endmodule

// ===== rtl/solar_charge_controller.sv =====
// Channel  | Dir | Word
// sample   | in  | tick, battery_sample, solar_sample, status_in
// result   | out | status_out, charge_enable, indicator, blue_pulse
// cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// One word per cycle sustained while result.ready holds; a sample passes through
// the input register, then the status logic into the output register.
// rst is synchronous; it clears the pipeline, the measurement and timer state
// and loads the register defaults.
// A stalled result holds in the output register while one more sample waits in
// the input register; sample.ready drops only when both are full.
module solar_charge_controller #(
  parameter int ADC_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [scc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [scc_pkg::CFG_DATA_W-1:0]  cfg_data,
  scc_in_if.sink                          sample,
  scc_out_if.source                       result
);
  import scc_pkg::*;

  cfg_t    cfg;
  result_t step_result;

  logic                s1_valid;
  logic                s1_tick;
  logic [ADC_BITS-1:0] s1_battery;
  logic [ADC_BITS-1:0] s1_solar;
  logic [1:0]          s1_status;
  logic                o_valid;
  result_t             o_word;
  logic                out_free;
  logic                advance;

  assign out_free     = !o_valid || result.ready;
  assign advance      = s1_valid && out_free;
  assign sample.ready = !s1_valid || out_free;

  scc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  scc_core #(
    .ADC_BITS (ADC_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .cfg            (cfg),
    .tick           (s1_tick),
    .battery_sample (s1_battery),
    .solar_sample   (s1_solar),
    .status_in      (s1_status),
    .result         (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (sample.valid && sample.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_tick    <= sample.tick;
      s1_battery <= sample.battery_sample;
      s1_solar   <= sample.solar_sample;
      s1_status  <= sample.status_in;
    end
    if (advance) begin
      o_word <= step_result;
    end
  end

  assign result.valid         = o_valid;
  assign result.status_out    = o_word.status_out;
  assign result.charge_enable = o_word.charge_enable;
  assign result.indicator     = o_word.indicator;
  assign result.blue_pulse    = o_word.blue_pulse;

endmodule
